// ===== rtl/core/lcd_rect_fill_byte_sequencer_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the rectangle fill byte sequencer
// Clocked property checks with and without a reset disable.
// ----------------------------------------------------------------------------
`ifndef LCD_RECT_FILL_BYTE_SEQUENCER_MACROS_SVH
`define LCD_RECT_FILL_BYTE_SEQUENCER_MACROS_SVH

`ifndef ASSERT_OFF

`define LRFS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lrfs assertion failed");

`define LRFS_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("lrfs assertion failed");

`else

`define LRFS_ASSERT(label, clk, rst, prop)

`define LRFS_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== rtl/core/lrfs_pkg.sv =====
// ----------------------------------------------------------------------------
// lrfs_pkg
// Types and constants shared by the rectangle fill byte sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lrfs_pkg;

   localparam logic OP_START = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   localparam logic [1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_SCREEN_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_ROW_OFFSET    = 2'd2;

   localparam logic [9:0] SCREEN_WIDTH_RESET  = 10'd128;
   localparam logic [9:0] SCREEN_HEIGHT_RESET = 10'd160;
   localparam logic [8:0] ROW_OFFSET_RESET    = 9'd0;

   localparam logic [7:0] CMD_COLUMN_SET = 8'h2A;
   localparam logic [7:0] CMD_ROW_SET    = 8'h2B;
   localparam logic [7:0] CMD_MEM_WRITE  = 8'h2C;

   localparam logic [3:0] STEP_COL_CMD      = 4'd0;
   localparam logic [3:0] STEP_COL_START_HI = 4'd1;
   localparam logic [3:0] STEP_COL_START_LO = 4'd2;
   localparam logic [3:0] STEP_COL_STOP_HI  = 4'd3;
   localparam logic [3:0] STEP_COL_STOP_LO  = 4'd4;
   localparam logic [3:0] STEP_ROW_CMD      = 4'd5;
   localparam logic [3:0] STEP_ROW_START_HI = 4'd6;
   localparam logic [3:0] STEP_ROW_START_LO = 4'd7;
   localparam logic [3:0] STEP_ROW_STOP_HI  = 4'd8;
   localparam logic [3:0] STEP_ROW_STOP_LO  = 4'd9;
   localparam logic [3:0] STEP_MEM_CMD      = 4'd10;

   localparam logic [1:0] QUEUE_DEPTH = 2'd2;

   typedef enum logic [1:0] {
      KIND_TICK,
      KIND_START,
      KIND_DROP
   } kind_type;

   typedef enum logic [1:0] {
      PHASE_IDLE,
      PHASE_PREAMBLE,
      PHASE_PIXELS
   } phase_type;

   typedef struct packed {
      logic        opcode;
      logic [9:0]  rect_x;
      logic [9:0]  rect_y;
      logic [9:0]  rect_width;
      logic [9:0]  rect_height;
      logic [15:0] fill_color;
   } req_type;

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] spi_byte;
      logic       is_data;
      logic       last_byte;
      logic       busy_res;
   } rsp_type;

   typedef struct packed {
      logic [9:0] screen_width;
      logic [9:0] screen_height;
      logic [8:0] row_offset;
   } cfg_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] column_start;
      logic [15:0] column_stop;
      logic [15:0] row_start;
      logic [15:0] row_stop;
      logic [15:0] color;
      logic [19:0] pixels;
   } entry_type;

endpackage

// ===== rtl/core/lrfs_front.sv =====
// ----------------------------------------------------------------------------
// lrfs_front
// Accepts items, clips start requests to the screen or marks them as drops,
// and builds queue entries with window addresses and pixel count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lrfs_front import lrfs_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      req_valid,
   output logic      req_ready,
   input  req_type   req_data,
   output logic      push_valid,
   input  logic      push_ready,
   output entry_type push_entry
);

   logic        a_valid_ff, a_valid_in;
   kind_type    a_kind_ff, a_kind_in;
   logic [9:0]  a_x_ff, a_y_ff, a_w_ff, a_h_ff;
   logic [9:0]  a_w_in, a_h_in;
   logic [15:0] a_color_ff;
   logic [10:0] x_sum, y_sum;
   logic        off_screen;
   logic        accept;
   logic [15:0] row_base;

   // clip
   always_comb begin
      x_sum      = {1'b0, req_data.rect_x} + {1'b0, req_data.rect_width};
      y_sum      = {1'b0, req_data.rect_y} + {1'b0, req_data.rect_height};
      off_screen = (req_data.rect_x >= cfg.screen_width) ||
                   (req_data.rect_y >= cfg.screen_height);
      if (req_data.rect_width != 10'd0 && x_sum > {1'b0, cfg.screen_width}) begin
         a_w_in = cfg.screen_width - req_data.rect_x;
      end else begin
         a_w_in = req_data.rect_width;
      end
      if (req_data.rect_height != 10'd0 && y_sum > {1'b0, cfg.screen_height}) begin
         a_h_in = cfg.screen_height - req_data.rect_y;
      end else begin
         a_h_in = req_data.rect_height;
      end
      if (req_data.opcode == OP_TICK) begin
         a_kind_in = KIND_TICK;
      end else if (off_screen) begin
         a_kind_in = KIND_DROP;
      end else begin
         a_kind_in = KIND_START;
      end
   end

   assign req_ready = !a_valid_ff || push_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      if (req_ready) begin
         a_valid_in = req_valid;
      end else begin
         a_valid_in = a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_kind_ff  <= a_kind_in;
         a_x_ff     <= req_data.rect_x;
         a_y_ff     <= req_data.rect_y;
         a_w_ff     <= a_w_in;
         a_h_ff     <= a_h_in;
         a_color_ff <= req_data.fill_color;
      end
   end

   // build entry
   always_comb begin
      row_base                = {6'd0, a_y_ff} + {7'd0, cfg.row_offset};
      push_valid              = a_valid_ff;
      push_entry.kind         = a_kind_ff;
      push_entry.column_start = {6'd0, a_x_ff};
      push_entry.column_stop  = {6'd0, a_x_ff} + {6'd0, a_w_ff} - 16'd1;
      push_entry.row_start    = row_base;
      push_entry.row_stop     = row_base + {6'd0, a_h_ff} - 16'd1;
      push_entry.color        = a_color_ff;
      push_entry.pixels       = {10'd0, a_w_ff} * {10'd0, a_h_ff};
   end

endmodule

// ===== rtl/core/lrfs_queue.sv =====
// ----------------------------------------------------------------------------
// lrfs_queue
// Two-entry queue between front and back; the head always sits in slot 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lrfs_queue import lrfs_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  entry_type push_entry,
   output logic      pop_valid,
   input  logic      pop_ready,
   output entry_type pop_entry
);

   entry_type  slot0_ff, slot1_ff;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_ready = count_ff != QUEUE_DEPTH;
   assign pop_valid  = count_ff != 2'd0;
   assign pop_entry  = slot0_ff;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (count_ff == QUEUE_DEPTH) begin
            slot0_ff <= slot1_ff;
         end else begin
            slot0_ff <= push_entry;
         end
         slot1_ff <= push_entry;
      end else if (push) begin
         if (count_ff == 2'd0) begin
            slot0_ff <= push_entry;
         end else begin
            slot1_ff <= push_entry;
         end
      end
   end

endmodule

// ===== rtl/core/lrfs_back.sv =====
// ----------------------------------------------------------------------------
// lrfs_back
// Runs the fill: preamble sequencer, pixel byte counter and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "lcd_rect_fill_byte_sequencer_macros.svh"

module lrfs_back import lrfs_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      pop_valid,
   output logic      pop_ready,
   input  entry_type pop_entry,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_data
);

   phase_type   phase_ff, phase_in;
   logic [3:0]  step_ff;
   logic [15:0] col_start_ff, col_stop_ff, row_start_ff, row_stop_ff, color_ff;
   logic [19:0] pixels_left_ff;
   logic        low_half_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff, rsp_in;
   logic        pop, pop_start, pop_tick;
   logic        pixel_byte;

   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign pop       = pop_valid && pop_ready;
   assign pop_start = pop && pop_entry.kind == KIND_START && phase_ff == PHASE_IDLE;
   assign pop_tick  = pop && pop_entry.kind == KIND_TICK;
   assign pixel_byte = pop_tick && phase_ff == PHASE_PIXELS && pixels_left_ff != 20'd0;

   // next state
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PHASE_IDLE: begin
            if (pop_start) begin
               phase_in = PHASE_PREAMBLE;
            end
         end
         PHASE_PREAMBLE: begin
            if (pop_tick && step_ff == STEP_MEM_CMD) begin
               phase_in = (pixels_left_ff == 20'd0) ? PHASE_IDLE : PHASE_PIXELS;
            end
         end
         PHASE_PIXELS: begin
            if (pop_tick && (pixels_left_ff == 20'd0 ||
                             (low_half_ff && pixels_left_ff == 20'd1))) begin
               phase_in = PHASE_IDLE;
            end
         end
         default: phase_in = PHASE_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      rsp_in            = '0;
      rsp_in.busy_res   = phase_in != PHASE_IDLE;
      if (pop_tick && phase_ff == PHASE_PREAMBLE) begin
         rsp_in.byte_valid = 1'b1;
         rsp_in.is_data    = 1'b1;
         rsp_in.last_byte  = step_ff == STEP_MEM_CMD && pixels_left_ff == 20'd0;
         unique case (step_ff)
            STEP_COL_CMD: begin
               rsp_in.spi_byte = CMD_COLUMN_SET;
               rsp_in.is_data  = 1'b0;
            end
            STEP_COL_START_HI: rsp_in.spi_byte = col_start_ff[15:8];
            STEP_COL_START_LO: rsp_in.spi_byte = col_start_ff[7:0];
            STEP_COL_STOP_HI:  rsp_in.spi_byte = col_stop_ff[15:8];
            STEP_COL_STOP_LO:  rsp_in.spi_byte = col_stop_ff[7:0];
            STEP_ROW_CMD: begin
               rsp_in.spi_byte = CMD_ROW_SET;
               rsp_in.is_data  = 1'b0;
            end
            STEP_ROW_START_HI: rsp_in.spi_byte = row_start_ff[15:8];
            STEP_ROW_START_LO: rsp_in.spi_byte = row_start_ff[7:0];
            STEP_ROW_STOP_HI:  rsp_in.spi_byte = row_stop_ff[15:8];
            STEP_ROW_STOP_LO:  rsp_in.spi_byte = row_stop_ff[7:0];
            default: begin
               rsp_in.spi_byte = CMD_MEM_WRITE;
               rsp_in.is_data  = 1'b0;
            end
         endcase
      end else if (pixel_byte) begin
         rsp_in.byte_valid = 1'b1;
         rsp_in.is_data    = 1'b1;
         rsp_in.spi_byte   = low_half_ff ? color_ff[7:0] : color_ff[15:8];
         rsp_in.last_byte  = low_half_ff && pixels_left_ff == 20'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (pop_ready) begin
            rsp_valid_ff <= pop_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
      if (pop_start) begin
         step_ff        <= STEP_COL_CMD;
         col_start_ff   <= pop_entry.column_start;
         col_stop_ff    <= pop_entry.column_stop;
         row_start_ff   <= pop_entry.row_start;
         row_stop_ff    <= pop_entry.row_stop;
         color_ff       <= pop_entry.color;
         pixels_left_ff <= pop_entry.pixels;
         low_half_ff    <= 1'b0;
      end else if (pop_tick && phase_ff == PHASE_PREAMBLE) begin
         step_ff <= step_ff + 4'd1;
      end else if (pixel_byte) begin
         low_half_ff <= !low_half_ff;
         if (low_half_ff) begin
            pixels_left_ff <= pixels_left_ff - 20'd1;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `LRFS_ASSERT(a_last_ends_fill, clock, reset, rsp_valid_ff && rsp_ff.last_byte |-> rsp_ff.byte_valid && !rsp_ff.busy_res)
   `LRFS_ASSERT(a_step_range, clock, reset, phase_ff == PHASE_PREAMBLE |-> step_ff <= STEP_MEM_CMD)
   `LRFS_ASSERT(a_pixels_pending, clock, reset, phase_ff == PHASE_PIXELS |-> pixels_left_ff != 20'd0)
   `LRFS_ASSERT(a_start_arms, clock, reset, pop_start |=> phase_ff == PHASE_PREAMBLE)
   `LRFS_ASSERT_ALWAYS(a_reset_idle, clock, !reset && $past(reset) |-> phase_ff == PHASE_IDLE && !rsp_valid_ff)

endmodule

// ===== rtl/core/lcd_rect_fill_byte_sequencer.sv =====
// ----------------------------------------------------------------------------
// lcd_rect_fill_byte_sequencer
// Turns rectangle fill requests and byte ticks into panel SPI bytes with
// command/data flag, window setup preamble and clipped pixel stream.
//
//   Channel  Dir  Handshake              Payload
//   req_     in   req_valid/req_ready    req_type (opcode, rect, color)
//   rsp_     out  rsp_valid/rsp_ready    rsp_type (byte, flags, busy)
//   csr_     in   csr_valid/csr_ready    csr_index, csr_data
//
// One item per cycle while neither side stalls; one result per item, passing
// in turn through the clip register, a queue slot and the result register.
// The 10x10 pixel count multiply and window adders sit between clip register and queue.
// Reset clears control state and loads register defaults; no clearing pass.
// Either side may stall; the two-entry queue and the result register absorb it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcd_rect_fill_byte_sequencer import lrfs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [9:0] csr_data
);

   cfg_type   cfg_ff;
   logic      push_valid, push_ready, pop_valid, pop_ready;
   entry_type push_entry, pop_entry;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width  <= SCREEN_WIDTH_RESET;
         cfg_ff.screen_height <= SCREEN_HEIGHT_RESET;
         cfg_ff.row_offset    <= ROW_OFFSET_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:  cfg_ff.screen_width  <= csr_data;
            CSR_SCREEN_HEIGHT: cfg_ff.screen_height <= csr_data;
            CSR_ROW_OFFSET:    cfg_ff.row_offset    <= csr_data[8:0];
            default: begin
            end
         endcase
      end
   end

   lrfs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   lrfs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   lrfs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
